// ===== src/sbht_pkg.sv =====
// shared widths, register map and stage record for the swept box hit-time block
package sbht_pkg;

    // coordinate arithmetic widths (positions and offsets are 32-bit, sizes 31-bit)
    localparam int EDGE_W = 34;
    localparam int NUM_W  = 35;
    localparam int DEN_W  = 33;
    localparam int DLT_W  = 33;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_WIDTH    = 2'd2;
    localparam logic [1:0] REG_HEIGHT   = 2'd3;

    // front-end result handed to the dividers and the decision stage
    typedef struct packed {
        logic signed [NUM_W-1:0] num_en_x;
        logic signed [NUM_W-1:0] num_ex_x;
        logic [DEN_W-1:0]        den_x;
        logic signed [NUM_W-1:0] num_en_y;
        logic signed [NUM_W-1:0] num_ex_y;
        logic [DEN_W-1:0]        den_y;
        logic                    dzero_x;
        logic                    dzero_y;
        logic                    apart;
        logic                    overlap;
    } t_front;

endpackage

// ===== src/sbht_front.sv =====
// box edges, per-axis gap numerators, delta magnitudes and early decisions (two stages)
module sbht_front (
    input  logic                         i_clk,
    input  logic                         i_ce,
    input  logic signed [31:0]           i_start_x,
    input  logic signed [31:0]           i_start_y,
    input  logic signed [31:0]           i_end_x,
    input  logic signed [31:0]           i_end_y,
    input  logic signed [31:0]           i_target_x,
    input  logic signed [31:0]           i_target_y,
    input  logic signed [31:0]           i_target_offset_x,
    input  logic signed [31:0]           i_target_offset_y,
    input  logic [30:0]                  i_target_width,
    input  logic [30:0]                  i_target_height,
    input  logic signed [31:0]           i_mover_offset_x,
    input  logic signed [31:0]           i_mover_offset_y,
    input  logic [30:0]                  i_mover_width,
    input  logic [30:0]                  i_mover_height,
    output sbht_pkg::t_front             o_front
);

    localparam int EW = sbht_pkg::EDGE_W;
    localparam int NW = sbht_pkg::NUM_W;
    localparam int DW = sbht_pkg::DLT_W;

    logic signed [EW-1:0] r_ml, r_mr, r_mt, r_mb, r_tl, r_tr, r_tt, r_tb;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [EW-1:0] n_ml, n_mt, n_tl, n_tt;
    sbht_pkg::t_front     r_front, n_front;

    // stage one: box edges and motion deltas
    always_comb begin
        n_ml = EW'(i_start_x) + EW'(i_mover_offset_x);
        n_mt = EW'(i_start_y) + EW'(i_mover_offset_y);
        n_tl = EW'(i_target_x) + EW'(i_target_offset_x);
        n_tt = EW'(i_target_y) + EW'(i_target_offset_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ml <= n_ml;
            r_mr <= n_ml + $signed({3'b000, i_mover_width});
            r_mt <= n_mt;
            r_mb <= n_mt + $signed({3'b000, i_mover_height});
            r_tl <= n_tl;
            r_tr <= n_tl + $signed({3'b000, i_target_width});
            r_tt <= n_tt;
            r_tb <= n_tt + $signed({3'b000, i_target_height});
            r_dx <= DW'(i_end_x) - DW'(i_start_x);
            r_dy <= DW'(i_end_y) - DW'(i_start_y);
        end
    end

    // stage two: signed gap numerators over the delta magnitude
    always_comb begin
        if (r_dx[DW-1]) begin
            n_front.num_en_x = NW'(r_ml) - NW'(r_tr);
            n_front.num_ex_x = NW'(r_mr) - NW'(r_tl);
            n_front.den_x    = sbht_pkg::DEN_W'(-r_dx);
        end else begin
            n_front.num_en_x = NW'(r_tl) - NW'(r_mr);
            n_front.num_ex_x = NW'(r_tr) - NW'(r_ml);
            n_front.den_x    = sbht_pkg::DEN_W'(r_dx);
        end
        if (r_dy[DW-1]) begin
            n_front.num_en_y = NW'(r_mt) - NW'(r_tb);
            n_front.num_ex_y = NW'(r_mb) - NW'(r_tt);
            n_front.den_y    = sbht_pkg::DEN_W'(-r_dy);
        end else begin
            n_front.num_en_y = NW'(r_tt) - NW'(r_mb);
            n_front.num_ex_y = NW'(r_tb) - NW'(r_mt);
            n_front.den_y    = sbht_pkg::DEN_W'(r_dy);
        end
        n_front.dzero_x = (r_dx == '0);
        n_front.dzero_y = (r_dy == '0);
        n_front.apart   = (n_front.dzero_x && ((r_mr < r_tl) || (r_ml > r_tr)))
                       || (n_front.dzero_y && ((r_mb < r_tt) || (r_mt > r_tb)));
        n_front.overlap = (r_ml < r_tr) && (r_mr > r_tl) && (r_mt < r_tb) && (r_mb > r_tt);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

// ===== src/sbht_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating at 2.0 and above
module sbht_div #(
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_ce,
    input  logic signed [sbht_pkg::NUM_W-1:0] i_num,
    input  logic [sbht_pkg::DEN_W-1:0]        i_den,
    output logic [TIME_FRAC_BITS:0]           o_quo,
    output logic                              o_neg,
    output logic                              o_sat
);

    localparam int NW = sbht_pkg::NUM_W;
    localparam int DW = sbht_pkg::DEN_W;
    localparam int NS = TIME_FRAC_BITS + 2;

    logic [NW-1:0]             r_rem [0:NS-1];
    logic [DW-1:0]             r_den [0:NS-1];
    logic [TIME_FRAC_BITS:0]   r_quo [0:NS-1];
    logic                      r_neg [0:NS-1];
    logic                      r_sat [0:NS-1];
    logic [NW-1:0]             n_mag;

    // entry stage: magnitude and quotient-overflow check (|n| >= 2|d|)
    assign n_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= n_mag;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_neg[0] <= i_num[NW-1];
            r_sat[0] <= {1'b0, n_mag} >= {i_den, 2'b00} >> 1;
        end
    end

    // one quotient bit per stage: integer bit first, then the fraction bits
    for (genvar k = 0; k < NS - 1; k++) begin : g_step
        logic [NW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_int
            assign trial = r_rem[k];
        end else begin : g_frac
            assign trial = {r_rem[k][NW-2:0], 1'b0};
        end
        assign take = trial >= NW'(r_den[k]);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k+1] <= take ? trial - NW'(r_den[k]) : trial;
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= {r_quo[k][TIME_FRAC_BITS-1:0], take};
                r_neg[k+1] <= r_neg[k];
                r_sat[k+1] <= r_sat[k];
            end
        end
    end

    assign o_quo = r_quo[NS-1];
    assign o_neg = r_neg[NS-1];
    assign o_sat = r_sat[NS-1];

endmodule

// ===== src/swept_box_hit_time.sv =====
// Swept box hit-time unit: one request per cycle while not stalled, passing through the front end,
// the four parallel dividers that resolve one quotient bit per pipeline stage, and the output register;
// a stall on the result side holds the whole pipeline, so o_stall follows i_stall while a
// result is waiting, and bubbles in the pipeline keep input open otherwise.
module swept_box_hit_time #(
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_offset_x,
    input  logic signed [31:0] i_target_offset_y,
    input  logic [30:0]        i_target_width,
    input  logic [30:0]        i_target_height,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic [16:0]        o_hit_time,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int T  = TIME_FRAC_BITS;
    localparam int TW = T + 3;
    localparam int NV = T + 4;
    localparam int NS = T + 2;
    localparam logic signed [TW-1:0] T_ONE = TW'(1 << T);
    localparam logic signed [TW-1:0] T_SAT = TW'((1 << T) + 1);

    logic signed [31:0] r_off_x, r_off_y;
    logic [30:0]        r_width, r_height;
    logic               ce;
    logic               r_vld [0:NV-1];
    logic               r_out_vld;
    logic               r_hit;
    logic [16:0]        r_hit_time;
    sbht_pkg::t_front   front;
    sbht_pkg::t_front   r_side [0:NS-1];

    logic [T:0]           quo_enx, quo_exx, quo_eny, quo_exy;
    logic                 neg_enx, neg_exx, neg_eny, neg_exy;
    logic                 sat_enx, sat_exx, sat_eny, sat_exy;
    logic signed [TW-1:0] enx, exx, eny, exy, entry, exit_t;
    logic                 n_hit;
    logic [16:0]          n_hit_time;

    // truncated quotient limited to [-1 lsb, 1.0 + 1 lsb]
    function automatic logic signed [TW-1:0] clamp_time(logic [T:0] q, logic neg, logic sat);
        logic signed [TW-1:0] v;
        v = $signed(TW'(q));
        if (neg) begin
            return (sat || q != '0) ? '1 : '0;
        end else if (sat || v > T_ONE) begin
            return T_SAT;
        end
        return v;
    endfunction

    // configuration registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                sbht_pkg::REG_OFFSET_X: r_off_x  <= pwdata;
                sbht_pkg::REG_OFFSET_Y: r_off_y  <= pwdata;
                sbht_pkg::REG_WIDTH:    r_width  <= pwdata[30:0];
                sbht_pkg::REG_HEIGHT:   r_height <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sbht_pkg::REG_OFFSET_X: prdata = r_off_x;
            sbht_pkg::REG_OFFSET_Y: prdata = r_off_y;
            sbht_pkg::REG_WIDTH:    prdata = {1'b0, r_width};
            sbht_pkg::REG_HEIGHT:   prdata = {1'b0, r_height};
            default:                prdata = '0;
        endcase
    end

    // pipeline advance: everything moves unless a finished result is held
    assign ce      = !(r_out_vld && i_stall);
    assign o_stall = !ce;

    // valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NV; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NV; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[NV-1];
        end
    end

    sbht_front u_front (
        .i_clk             (i_clk),
        .i_ce              (ce),
        .i_start_x         (i_start_x),
        .i_start_y         (i_start_y),
        .i_end_x           (i_end_x),
        .i_end_y           (i_end_y),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .i_target_offset_x (i_target_offset_x),
        .i_target_offset_y (i_target_offset_y),
        .i_target_width    (i_target_width),
        .i_target_height   (i_target_height),
        .i_mover_offset_x  (r_off_x),
        .i_mover_offset_y  (r_off_y),
        .i_mover_width     (r_width),
        .i_mover_height    (r_height),
        .o_front           (front)
    );

    sbht_div #(.TIME_FRAC_BITS(T)) u_div_enx (
        .i_clk(i_clk), .i_ce(ce), .i_num(front.num_en_x), .i_den(front.den_x),
        .o_quo(quo_enx), .o_neg(neg_enx), .o_sat(sat_enx)
    );
    sbht_div #(.TIME_FRAC_BITS(T)) u_div_exx (
        .i_clk(i_clk), .i_ce(ce), .i_num(front.num_ex_x), .i_den(front.den_x),
        .o_quo(quo_exx), .o_neg(neg_exx), .o_sat(sat_exx)
    );
    sbht_div #(.TIME_FRAC_BITS(T)) u_div_eny (
        .i_clk(i_clk), .i_ce(ce), .i_num(front.num_en_y), .i_den(front.den_y),
        .o_quo(quo_eny), .o_neg(neg_eny), .o_sat(sat_eny)
    );
    sbht_div #(.TIME_FRAC_BITS(T)) u_div_exy (
        .i_clk(i_clk), .i_ce(ce), .i_num(front.num_ex_y), .i_den(front.den_y),
        .o_quo(quo_exy), .o_neg(neg_exy), .o_sat(sat_exy)
    );

    // early decisions ride alongside the dividers
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= front;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // interval intersection and hit decision
    always_comb begin
        enx = r_side[NS-1].dzero_x ? '1    : clamp_time(quo_enx, neg_enx, sat_enx);
        exx = r_side[NS-1].dzero_x ? T_SAT : clamp_time(quo_exx, neg_exx, sat_exx);
        eny = r_side[NS-1].dzero_y ? '1    : clamp_time(quo_eny, neg_eny, sat_eny);
        exy = r_side[NS-1].dzero_y ? T_SAT : clamp_time(quo_exy, neg_exy, sat_exy);
        entry  = (enx > eny) ? enx : eny;
        exit_t = (exx < exy) ? exx : exy;
        n_hit_time = '0;
        if (r_side[NS-1].overlap) begin
            n_hit = 1'b1;
        end else if (!r_side[NS-1].apart && entry <= exit_t && entry >= 0 && entry <= T_ONE) begin
            n_hit      = 1'b1;
            n_hit_time = 17'($unsigned(entry));
        end else begin
            n_hit = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hit      <= n_hit;
            r_hit_time <= n_hit_time;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_hit      = r_hit;
    assign o_hit_time = r_hit_time;

endmodule

// ===== src/sbht_checker.sv =====
// port-level checks for the swept box hit-time unit, bound to the top level
module sbht_checker #(
    parameter int TIME_FRAC_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_stall,
    input logic        o_valid,
    input logic        o_hit,
    input logic [16:0] o_hit_time
);

    // a miss always reports time zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hit_time == '0)
        else $error("miss with nonzero hit time");

    // a hit time never exceeds 1.0 when it fits the field
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> (TIME_FRAC_BITS > 16) || (o_hit_time <= 17'(1 << TIME_FRAC_BITS)))
        else $error("hit time above one");

    // input side is only held back by a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_hit_time))
        else $error("stalled result changed");

endmodule

bind swept_box_hit_time sbht_checker #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_sbht_checker (.*);
